[design/nmea_sentence_framer_assert.svh]
// assertion macros for the nmea sentence framer
// expects clk and rst_n in the scope of use
`ifndef NMEA_SENTENCE_FRAMER_ASSERT_SVH
`define NMEA_SENTENCE_FRAMER_ASSERT_SVH

// same-cycle implication
`define NSF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NSF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/nmea_pkg.sv]
// shared types, character constants and helpers for the nmea sentence framer
// no dependencies
`default_nettype none
package nmea_pkg;

  localparam logic [7:0] MAX_LEN     = 8'd128;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] HEX_DIGIT0  = 8'h30;
  localparam logic [7:0] HEX_ALPHA   = 8'h41;
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  localparam int NUM_TYPES = 7;

  typedef enum logic [2:0] {
    ST_RMC   = 3'd0,
    ST_GGA   = 3'd1,
    ST_GST   = 3'd2,
    ST_GSA   = 3'd3,
    ST_VTG   = 3'd4,
    ST_GSV   = 3'd5,
    ST_GLL   = 3'd6,
    ST_OTHER = 3'd7
  } sent_type_t;

  typedef enum logic {
    STATUS_ACCEPT = 1'b0,
    STATUS_REJECT = 1'b1
  } status_t;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_DATA   = 6'b000010,
    PH_HEX_HI = 6'b000100,
    PH_HEX_LO = 6'b001000,
    PH_END0   = 6'b010000,
    PH_END1   = 6'b100000
  } phase_t;

  // first character in the top byte
  localparam logic [23:0] TYPE_NAMES [NUM_TYPES] = '{
    {8'h52, 8'h4D, 8'h43},  // RMC
    {8'h47, 8'h47, 8'h41},  // GGA
    {8'h47, 8'h53, 8'h54},  // GST
    {8'h47, 8'h53, 8'h41},  // GSA
    {8'h56, 8'h54, 8'h47},  // VTG
    {8'h47, 8'h53, 8'h56},  // GSV
    {8'h47, 8'h4C, 8'h4C}   // GLL
  };

  // uppercase hex character of a nibble
  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    logic [3:0] m;
    m = n & NIBBLE_MASK;
    if (m < 4'd10) begin
      nibble_char = HEX_DIGIT0 + {4'd0, m};
    end else begin
      nibble_char = HEX_ALPHA + {4'd0, m} - 8'd10;
    end
  endfunction

endpackage
`default_nettype wire

[design/nmea_classify.sv]
// maps the three sentence-type characters to a type code
// depends on nmea_pkg
`default_nettype none
module nmea_classify (
  input  wire logic [2:0][7:0]          type_chars,  // [2] first character
  output nmea_pkg::sent_type_t          sent_type
);
  import nmea_pkg::*;

  logic [23:0] key;

  assign key = {type_chars[2], type_chars[1], type_chars[0]};

  // names are distinct, so at most one matches
  always_comb begin
    sent_type = ST_OTHER;
    for (int k = NUM_TYPES - 1; k >= 0; k--) begin
      if (key == TYPE_NAMES[k]) begin
        sent_type = sent_type_t'(k[2:0]);
      end
    end
  end

endmodule
`default_nettype wire

[design/nmea_sentence_framer.sv]
// top level of the nmea 0183 sentence framer: byte input register, parse state, result register
// depends on nmea_pkg, nmea_classify and nmea_sentence_framer_assert.svh
`default_nettype none
// Takes one received byte per cycle and produces a result when a sentence
// ends (two further bytes after a matching checksum) or when a checksum
// character mismatches. A byte is held in the input register and is
// parsed from there; its result, if any, is registered in the result
// register. Throughput is one byte per clock when not stalled. The
// input register keeps taking a byte while a result waits at the output;
// only a second result blocked behind an untaken one stalls the input.
// Type characters are captured from payload bytes three to five; a sentence
// with fewer payload bytes reuses those of the previous sentence.
module nmea_sentence_framer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [2:0] sentence_type, [10:3] sentence_length,
                                       // [18:11] checksum_value, [23:19] zero
  output logic             out_tuser   // [0] status
);
  import nmea_pkg::*;

  `include "nmea_sentence_framer_assert.svh"

  logic       in_valid_r;
  logic [7:0] in_byte_r;

  phase_t     phase_r, phase_nxt;
  logic [7:0] csum_r, csum_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] len_r, len_nxt;
  logic [2:0][7:0] tchars_r;

  logic       tc_we;
  logic [1:0] tc_idx;
  logic       emit;
  status_t    emit_status;
  logic       advance;
  logic [7:0] len_bump;
  logic [7:0] cnt_inc;
  sent_type_t cur_type;

  logic       out_valid_r;
  status_t    out_status_r;
  sent_type_t out_type_r;
  logic [7:0] out_len_r;
  logic [7:0] out_csum_r;

  nmea_classify u_classify (
    .type_chars (tchars_r),
    .sent_type  (cur_type)
  );

  assign len_bump = (len_r < MAX_LEN) ? len_r + 8'd1 : len_r;
  assign cnt_inc  = (cnt_r < MAX_LEN) ? cnt_r + 8'd1 : cnt_r;

  always_comb begin
    phase_nxt   = phase_r;
    csum_nxt    = csum_r;
    cnt_nxt     = cnt_r;
    len_nxt     = len_r;
    tc_we       = 1'b0;
    tc_idx      = 2'd0;
    emit        = 1'b0;
    emit_status = STATUS_ACCEPT;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_byte_r == CHAR_DOLLAR) begin
          phase_nxt = PH_DATA;
          cnt_nxt   = 8'd0;
          len_nxt   = 8'd1;
        end
      end
      PH_DATA: begin
        len_nxt = len_bump;
        if (in_byte_r == CHAR_STAR) begin
          phase_nxt = PH_HEX_HI;
        end else begin
          cnt_nxt  = cnt_inc;
          csum_nxt = csum_r ^ in_byte_r;
          if (cnt_inc >= 8'd3 && cnt_inc <= 8'd5) begin
            tc_we  = 1'b1;
            tc_idx = cnt_inc[1:0] - 2'd3;
          end
        end
      end
      PH_HEX_HI: begin
        if (nibble_char(csum_r[7:4]) == in_byte_r) begin
          len_nxt   = len_bump;
          phase_nxt = PH_HEX_LO;
        end else begin
          emit        = 1'b1;
          emit_status = STATUS_REJECT;
        end
      end
      PH_HEX_LO: begin
        if (nibble_char(csum_r[3:0]) == in_byte_r) begin
          len_nxt   = len_bump;
          phase_nxt = PH_END0;
        end else begin
          emit        = 1'b1;
          emit_status = STATUS_REJECT;
        end
      end
      PH_END0: begin
        phase_nxt = PH_END1;
      end
      PH_END1: begin
        emit        = 1'b1;
        emit_status = STATUS_ACCEPT;
      end
      default: begin
        phase_nxt = PH_IDLE;
        csum_nxt  = 8'd0;
      end
    endcase
    if (emit) begin
      phase_nxt = PH_IDLE;
      csum_nxt  = 8'd0;
    end
  end

  // a byte with no result may pass even while the output is blocked
  assign advance   = in_valid_r && (!emit || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      csum_r  <= 8'd0;
      cnt_r   <= 8'd0;
      len_r   <= 8'd0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      csum_r  <= csum_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
    end
  end

  // sentence-type characters, third payload byte lands in the top slot
  always_ff @(posedge clk) begin
    if (advance && tc_we) begin
      tchars_r[2'd2 - tc_idx] <= in_byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_status_r <= emit_status;
      out_type_r   <= cur_type;
      out_len_r    <= len_r;
      out_csum_r   <= csum_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_csum_r, out_len_r, out_type_r};
  assign out_tuser  = out_status_r;

  `NSF_ASSERT_NXT(a_idle_after_emit, advance && emit,
                  phase_r == PH_IDLE && csum_r == 8'd0, "state not cleared after result")
  `NSF_ASSERT_IMP(a_len_bounded, 1'b1, len_r <= MAX_LEN && cnt_r <= MAX_LEN,
                  "length count beyond limit")
  `NSF_ASSERT_NXT(a_blocked_result_holds, in_valid_r && emit && out_valid_r && !out_tready,
                  in_valid_r && emit, "blocked result byte dropped")

endmodule
`default_nettype wire
